FILE: rtl/pese_pkg.sv
// shared types and constants for the prefix expression stack evaluator
// no dependencies; imported by the core top level (pese_ram does not use it)
package pese_pkg;

    localparam int DATA_W           = 32;
    localparam int CNT_W            = $clog2(DATA_W);
    localparam int PESE_STACK_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_LEFTOVER  = 3'd4
    } t_status;

    typedef struct packed {
        logic       is_operator;
        logic [3:0] digit_value;
        logic [1:0] opcode;
        logic       end_of_expression;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [2:0]               status;
    } t_out_item;

endpackage

FILE: rtl/pese_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module pese_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/prefix_expression_stack_evaluator_core.sv
// prefix expression evaluator: symbols arrive last symbol first, one transfer each.
// digits push onto an operand stack in RAM; operators run through a serial datapath
// that handles one bit (add/subtract) or one multiplier/quotient bit per cycle.
// the input channel takes a symbol only while the core is idle; a digit is pushed
// as it is taken and the core stays idle, while an operator runs two stack reads,
// a setup step, 32 serial steps and a write-back before the core is idle again.
// on a symbol flagged end_of_expression the top of stack is read (S_RD_FIN) and then,
// in S_EMIT, goes with a status to the output register; the stack and error are cleared.
// the output register holds a result while i_out_stall is high; the core keeps
// accepting symbols meanwhile and only waits if a second result is ready first.
// reset clears stack depth, sticky error and the output valid; the stack RAM
// needs no clearing since only entries below the depth are read.
// uses pese_pkg and pese_ram
module prefix_expression_stack_evaluator_core #(
    parameter int STACK_DEPTH = pese_pkg::PESE_STACK_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pese_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pese_pkg::t_out_item o_out_item
);

    import pese_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD1    = 8'b0000_0010,
        S_RD2    = 8'b0000_0100,
        S_PREP   = 8'b0000_1000,
        S_EXEC   = 8'b0001_0000,
        S_POST   = 8'b0010_0000,
        S_RD_FIN = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [DW-1:0]       r_depth, n_depth;
    t_status             r_err, n_err;
    t_opcode             r_op, n_op;
    logic                r_last, n_last;
    logic [DATA_W-1:0]   r_a, n_a;
    logic [DATA_W-1:0]   r_b, n_b;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic                r_carry, n_carry;
    logic                r_neg, n_neg;
    logic                r_dz, n_dz;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic                w_accept;
    logic                w_we, w_re;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [DATA_W-1:0]   w_wdata, w_rdata;
    logic [DW-1:0]       w_depth_m1, w_depth_m2;
    logic                w_sum_bit, w_b_bit;
    logic [DATA_W:0]     w_trial, w_diff;
    logic [DATA_W-1:0]   w_result;
    logic                w_emit;

    pese_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_depth_m1  = r_depth - DW'(1);
    assign w_depth_m2  = r_depth - DW'(2);
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // bit-serial add/subtract step
    assign w_b_bit   = r_b[0] ^ (r_op == OP_SUB);
    assign w_sum_bit = r_a[0] ^ w_b_bit ^ r_carry;

    // restoring division step: remainder in r_acc, dividend/quotient in r_a
    assign w_trial = {r_acc, r_a[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_b};

    always_comb begin
        if (r_op == OP_DIV) begin
            if (r_dz) begin
                w_result = '0;
            end else if (r_neg) begin
                w_result = DATA_W'(0) - r_a;
            end else begin
                w_result = r_a;
            end
        end else begin
            w_result = r_acc;
        end
    end

    // stack RAM ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_depth[AW-1:0];
        w_wdata = DATA_W'(i_in_item.digit_value);
        w_re    = 1'b0;
        w_raddr = w_depth_m1[AW-1:0];
        if (w_accept && !i_in_item.is_operator && (r_depth < DW'(STACK_DEPTH))) begin
            w_we = 1'b1;
        end
        if (r_state == S_POST) begin
            w_we    = 1'b1;
            w_waddr = w_depth_m2[AW-1:0];
            w_wdata = w_result;
        end
        if (r_state == S_RD1 || (r_state == S_RD_FIN && r_depth != '0)) begin
            w_re = 1'b1;
        end
        if (r_state == S_RD2) begin
            w_re    = 1'b1;
            w_raddr = w_depth_m2[AW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_err       = r_err;
        n_op        = r_op;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_carry     = r_carry;
        n_neg       = r_neg;
        n_dz        = r_dz;
        n_cnt       = r_cnt;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = t_opcode'(i_in_item.opcode);
                    n_last = i_in_item.end_of_expression;
                    n_state = i_in_item.end_of_expression ? S_RD_FIN : S_IDLE;
                    if (!i_in_item.is_operator) begin
                        if (r_depth < DW'(STACK_DEPTH)) begin
                            n_depth = r_depth + DW'(1);
                        end else if (r_err == ST_OK) begin
                            n_err = ST_OVERFLOW;
                        end
                    end else if (r_depth < DW'(2)) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_UNDERFLOW;
                        end
                    end else begin
                        n_state = S_RD1;
                    end
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                n_a     = w_rdata;
                n_state = S_PREP;
            end
            S_PREP: begin
                // read data now holds the second operand
                n_acc   = '0;
                n_cnt   = '0;
                n_carry = (r_op == OP_SUB);
                n_b     = w_rdata;
                n_dz    = (w_rdata == '0);
                n_neg   = r_a[DATA_W-1] ^ w_rdata[DATA_W-1];
                if (r_op == OP_DIV) begin
                    if (r_a[DATA_W-1]) begin
                        n_a = DATA_W'(0) - r_a;
                    end
                    if (w_rdata[DATA_W-1]) begin
                        n_b = DATA_W'(0) - w_rdata;
                    end
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_op)
                    OP_MUL: begin
                        if (r_b[0]) begin
                            n_acc = r_acc + r_a;
                        end
                        n_a = {r_a[DATA_W-2:0], 1'b0};
                        n_b = {1'b0, r_b[DATA_W-1:1]};
                    end
                    OP_DIV: begin
                        if (!w_diff[DATA_W]) begin
                            n_acc = w_diff[DATA_W-1:0];
                            n_a   = {r_a[DATA_W-2:0], 1'b1};
                        end else begin
                            n_acc = w_trial[DATA_W-1:0];
                            n_a   = {r_a[DATA_W-2:0], 1'b0};
                        end
                    end
                    default: begin
                        n_acc   = {w_sum_bit, r_acc[DATA_W-1:1]};
                        n_carry = (r_a[0] & w_b_bit) | (r_carry & (r_a[0] ^ w_b_bit));
                        n_a     = {1'b0, r_a[DATA_W-1:1]};
                        n_b     = {1'b0, r_b[DATA_W-1:1]};
                    end
                endcase
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                // pop two, push one
                n_depth = w_depth_m1;
                if (r_op == OP_DIV && r_dz && r_err == ST_OK) begin
                    n_err = ST_DIVZERO;
                end
                n_state = r_last ? S_RD_FIN : S_IDLE;
            end
            S_RD_FIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_out_item.result_value = (r_depth != '0) ? w_rdata : '0;
                    if (r_err != ST_OK) begin
                        n_out_item.status = r_err;
                    end else if (r_depth != DW'(1)) begin
                        n_out_item.status = ST_LEFTOVER;
                    end else begin
                        n_out_item.status = ST_OK;
                    end
                    n_depth = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_last     <= n_last;
        r_a        <= n_a;
        r_b        <= n_b;
        r_acc      <= n_acc;
        r_carry    <= n_carry;
        r_neg      <= n_neg;
        r_dz       <= n_dz;
        r_cnt      <= n_cnt;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
